@@ rtl/core/svl_pkg.sv @@
// Shared types, field widths and codes for the vertex list linker.
// Depends on nothing; every other file of the block but svl_ram imports it.
package svl_pkg;

  // Field widths
  localparam int REQ_W     = 2;
  localparam int SLOT_W    = 12;
  localparam int SITE_W    = 10;
  localparam int ADDR_W    = 14;
  localparam int VTX_W     = 15;

  // Stream bus widths
  localparam int S_DATA_W  = 40;
  localparam int S_USER_W  = 2;
  localparam int M_DATA_W  = 32;

  // Defaults and fixed limits
  localparam int MAX_SITES_DEF = 1024;
  localparam int MAX_SLOTS     = 4096;
  localparam int MAX_WRITES    = 4;
  localparam int Q_DEPTH       = 2;

  // No vertex: -1 in 15 bits
  localparam logic [VTX_W-1:0] NO_VERTEX = '1;

  // Request codes on the input bus
  localparam logic [REQ_W-1:0] REQ_START = 2'd0;
  localparam logic [REQ_W-1:0] REQ_SLOT  = 2'd1;
  localparam logic [REQ_W-1:0] REQ_CLOSE = 2'd2;

  // Command kinds passed from front to back
  typedef enum logic [1:0] {
    CMD_START,
    CMD_EMPTY,
    CMD_OP,
    CMD_CLOSE
  } cmd_kind_t;

  // One queued command
  typedef struct packed {
    cmd_kind_t         kind;
    logic [SLOT_W-1:0] slot;
    logic [SITE_W-1:0] site_a;
    logic [SITE_W-1:0] site_b;
    logic              a_ok;
    logic              b_ok;
  } cmd_t;

  // Back end sequencer states
  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_RD_B,
    ST_OP_CHK,
    ST_OP_WR2,
    ST_CLOSE_CHK,
    ST_EMIT
  } back_state_t;

endpackage

@@ rtl/core/svl_ram.sv @@
// Generic single write port, single read port RAM with registered read.
// Depends on nothing.
module svl_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write and read; a read at the write address returns the old data
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

@@ rtl/core/svl_front.sv @@
// Front end: accepts input transfers, drops ignored requests and classifies
// the rest into queue commands. Depends on svl_pkg.
module svl_front #(
  parameter int MAX_SITES = svl_pkg::MAX_SITES_DEF
) (
  input  logic                        s_tvalid,
  output logic                        s_tready,
  input  logic [svl_pkg::S_DATA_W-1:0] s_tdata,
  input  logic [svl_pkg::S_USER_W-1:0] s_tuser,
  input  logic                        q_full,
  input  logic                        clearing,
  output logic                        q_push,
  output svl_pkg::cmd_t               q_entry
);
  import svl_pkg::*;

  logic [SLOT_W-1:0] slot;
  logic              occ;
  logic [SITE_W-1:0] site_a;
  logic [SITE_W-1:0] site_b;
  logic              slot_ok;
  logic              keep;
  cmd_kind_t         kind;

  // Unpack the data bus
  assign slot   = s_tdata[11:0];
  assign occ    = s_tdata[12];
  assign site_a = s_tdata[22:13];
  assign site_b = s_tdata[32:23];

  assign slot_ok = 32'(slot) < 32'(MAX_SLOTS);

  // Hold off while the queue is full or the tables are being swept
  assign s_tready = !q_full && !clearing;

  // Classify the request
  always_comb begin
    keep = 1'b0;
    kind = CMD_START;
    case (s_tuser)
      REQ_START: begin
        keep = 1'b1;
        kind = CMD_START;
      end
      REQ_SLOT: begin
        keep = slot_ok;
        kind = occ ? CMD_OP : CMD_EMPTY;
      end
      REQ_CLOSE: begin
        keep = 1'b1;
        kind = CMD_CLOSE;
      end
      default: begin
        keep = 1'b0;
        kind = CMD_START;
      end
    endcase
  end

  // Build the queue entry; sites beyond the table count as having no vertex
  always_comb begin
    q_entry.kind   = kind;
    q_entry.slot   = slot;
    q_entry.site_a = site_a;
    q_entry.site_b = site_b;
    q_entry.a_ok   = 32'(site_a) < 32'(MAX_SITES);
    q_entry.b_ok   = 32'(site_b) < 32'(MAX_SITES);
  end

  assign q_push = s_tvalid && s_tready && keep;

endmodule

@@ rtl/core/svl_queue.sv @@
// Short command queue between front and back end, held in flip-flops.
// Depends on svl_pkg.
module svl_queue (
  input  logic          clk,
  input  logic          rst,
  input  logic          push,
  input  svl_pkg::cmd_t push_entry,
  output logic          full,
  input  logic          pop,
  output svl_pkg::cmd_t head,
  output logic          empty
);
  import svl_pkg::*;

  localparam int QAW = (Q_DEPTH > 1) ? $clog2(Q_DEPTH) : 1;
  localparam int CW  = $clog2(Q_DEPTH + 1);

  cmd_t           slots [Q_DEPTH];
  logic [QAW-1:0] wr_ptr;
  logic [QAW-1:0] rd_ptr;
  logic [CW-1:0]  count;

  assign full  = count == CW'(Q_DEPTH);
  assign empty = count == '0;
  assign head  = slots[rd_ptr];

  // Store pushed entries
  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= push_entry;
    end
  end

  // Advance pointers and count
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == QAW'(Q_DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == QAW'(Q_DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

@@ rtl/core/svl_back.sv @@
// Back end: sequences table sweeps, table reads and updates, and emits the
// vertex list writes through an output register. Depends on svl_pkg, svl_ram.
module svl_back #(
  parameter int MAX_SITES = svl_pkg::MAX_SITES_DEF
) (
  input  logic                         clk,
  input  logic                         rst,
  input  svl_pkg::cmd_t                head,
  input  logic                         q_empty,
  output logic                         q_pop,
  output logic                         clearing,
  output logic                         m_tvalid,
  input  logic                         m_tready,
  output logic [svl_pkg::M_DATA_W-1:0] m_tdata,
  output logic                         m_tlast
);
  import svl_pkg::*;

  localparam int SITE_AW = $clog2(MAX_SITES);
  localparam logic [SITE_AW-1:0] CLR_LAST = SITE_AW'(MAX_SITES - 1);
  localparam int EIW = $clog2(MAX_WRITES);
  localparam int ECW = $clog2(MAX_WRITES + 1);

  back_state_t      state;
  back_state_t      state_next;
  logic [SITE_AW-1:0] clr_cnt;
  cmd_t             cmd;
  logic [VTX_W-1:0] v1;
  logic [VTX_W-1:0] v2;
  logic [ADDR_W-1:0] ent_addr [MAX_WRITES];
  logic [VTX_W-1:0]  ent_val  [MAX_WRITES];
  logic [ECW-1:0]   ent_cnt;
  logic [EIW-1:0]   emit_idx;

  // Table ports
  logic               first_we;
  logic [SITE_AW-1:0] first_waddr;
  logic [VTX_W-1:0]   first_wdata;
  logic [SITE_AW-1:0] first_raddr;
  logic [VTX_W-1:0]   first_rdata;
  logic               last_we;
  logic [SITE_AW-1:0] last_waddr;
  logic [VTX_W-1:0]   last_wdata;
  logic [SITE_AW-1:0] last_raddr;
  logic [VTX_W-1:0]   last_rdata;

  // Derived values
  logic [SITE_AW-1:0] idx_a;
  logic [SITE_AW-1:0] idx_b;
  logic [VTX_W-1:0]   v2_cur;
  logic [VTX_W-1:0]   cl_last;
  logic [VTX_W-1:0]   cl_first;
  logic               close_hit;
  logic               out_load;
  logic               emit_last;
  logic [ADDR_W-1:0]  leg0;
  logic [ADDR_W-1:0]  leg1;

  assign idx_a = SITE_AW'(cmd.site_a);
  assign idx_b = SITE_AW'(cmd.site_b);
  assign leg0  = {cmd.slot, 2'd0};
  assign leg1  = {cmd.slot, 2'd1};

  assign v2_cur    = cmd.b_ok ? last_rdata : NO_VERTEX;
  assign cl_last   = cmd.a_ok ? last_rdata : NO_VERTEX;
  assign cl_first  = cmd.a_ok ? first_rdata : NO_VERTEX;
  assign close_hit = (cl_last != NO_VERTEX) && (cl_first != NO_VERTEX);

  assign emit_last = ECW'(emit_idx) == (ent_cnt - 1'b1);

  svl_ram #(.WIDTH(VTX_W), .DEPTH(MAX_SITES)) first_ram (
    .clk   (clk),
    .we    (first_we),
    .waddr (first_waddr),
    .wdata (first_wdata),
    .raddr (first_raddr),
    .rdata (first_rdata)
  );

  svl_ram #(.WIDTH(VTX_W), .DEPTH(MAX_SITES)) last_ram (
    .clk   (clk),
    .we    (last_we),
    .waddr (last_waddr),
    .wdata (last_wdata),
    .raddr (last_raddr),
    .rdata (last_rdata)
  );

  // Next state
  always_comb begin
    state_next = state;
    case (state)
      ST_CLEAR: begin
        if (clr_cnt == CLR_LAST) state_next = ST_IDLE;
      end
      ST_IDLE: begin
        if (!q_empty) begin
          case (head.kind)
            CMD_START: state_next = ST_CLEAR;
            CMD_EMPTY: state_next = ST_EMIT;
            CMD_OP:    state_next = ST_RD_B;
            CMD_CLOSE: state_next = ST_CLOSE_CHK;
            default:   state_next = ST_IDLE;
          endcase
        end
      end
      ST_RD_B:      state_next = ST_OP_CHK;
      ST_OP_CHK:    state_next = ST_OP_WR2;
      ST_OP_WR2:    state_next = (ent_cnt == '0) ? ST_IDLE : ST_EMIT;
      ST_CLOSE_CHK: state_next = close_hit ? ST_EMIT : ST_IDLE;
      ST_EMIT: begin
        if (out_load && emit_last) state_next = ST_IDLE;
      end
      default: state_next = ST_IDLE;
    endcase
  end

  // Control outputs and table port selection
  always_comb begin
    q_pop       = 1'b0;
    clearing    = 1'b0;
    out_load    = 1'b0;
    first_we    = 1'b0;
    first_waddr = idx_a;
    first_wdata = NO_VERTEX;
    first_raddr = SITE_AW'(head.site_a);
    last_we     = 1'b0;
    last_waddr  = idx_a;
    last_wdata  = NO_VERTEX;
    last_raddr  = SITE_AW'(head.site_a);
    case (state)
      ST_CLEAR: begin
        clearing    = 1'b1;
        first_we    = 1'b1;
        first_waddr = clr_cnt;
        last_we     = 1'b1;
        last_waddr  = clr_cnt;
      end
      ST_IDLE: begin
        q_pop = !q_empty;
      end
      ST_RD_B: begin
        last_raddr = idx_b;
      end
      ST_OP_CHK: begin
        // Entry and exit legs of the first site
        first_we    = cmd.a_ok && (v1 == NO_VERTEX);
        first_waddr = idx_a;
        first_wdata = {1'b0, leg0};
        last_we     = cmd.a_ok;
        last_waddr  = idx_a;
        last_wdata  = {1'b0, cmd.slot, 2'd2};
      end
      ST_OP_WR2: begin
        // Second site last, so it wins when both sites are equal
        first_we    = cmd.b_ok && (v2 == NO_VERTEX);
        first_waddr = idx_b;
        first_wdata = {1'b0, leg1};
        last_we     = cmd.b_ok;
        last_waddr  = idx_b;
        last_wdata  = {1'b0, cmd.slot, 2'd3};
      end
      ST_CLOSE_CHK: begin
      end
      ST_EMIT: begin
        out_load = !m_tvalid || m_tready;
      end
      default: begin
      end
    endcase
  end

  // State and sweep counter
  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= ST_CLEAR;
      clr_cnt  <= '0;
      ent_cnt  <= '0;
      emit_idx <= '0;
    end else begin
      state <= state_next;
      if (state == ST_CLEAR) begin
        clr_cnt <= clr_cnt + 1'b1;
      end else begin
        clr_cnt <= '0;
      end
      // Result count and emit position
      case (state)
        ST_IDLE: begin
          emit_idx <= '0;
          if (!q_empty && head.kind == CMD_EMPTY) ent_cnt <= ECW'(MAX_WRITES);
        end
        ST_OP_CHK: begin
          ent_cnt <= ECW'({(v1 != NO_VERTEX), 1'b0}) + ECW'({(v2_cur != NO_VERTEX), 1'b0});
        end
        ST_CLOSE_CHK: begin
          ent_cnt <= close_hit ? ECW'(2) : '0;
        end
        ST_EMIT: begin
          if (out_load) emit_idx <= emit_idx + 1'b1;
        end
        default: begin
        end
      endcase
    end
  end

  // Command, read values and result list
  always_ff @(posedge clk) begin
    case (state)
      ST_IDLE: begin
        if (!q_empty) begin
          cmd <= head;
          for (int i = 0; i < MAX_WRITES; i++) begin
            ent_addr[i] <= {head.slot, 2'(i)};
            ent_val[i]  <= NO_VERTEX;
          end
        end
      end
      ST_RD_B: begin
        v1 <= cmd.a_ok ? last_rdata : NO_VERTEX;
      end
      ST_OP_CHK: begin
        v2 <= v2_cur;
        if (v1 != NO_VERTEX) begin
          ent_addr[0] <= v1[ADDR_W-1:0];
          ent_val[0]  <= {1'b0, leg0};
          ent_addr[1] <= leg0;
          ent_val[1]  <= v1;
          ent_addr[2] <= v2_cur[ADDR_W-1:0];
          ent_val[2]  <= {1'b0, leg1};
          ent_addr[3] <= leg1;
          ent_val[3]  <= v2_cur;
        end else begin
          ent_addr[0] <= v2_cur[ADDR_W-1:0];
          ent_val[0]  <= {1'b0, leg1};
          ent_addr[1] <= leg1;
          ent_val[1]  <= v2_cur;
        end
      end
      ST_CLOSE_CHK: begin
        ent_addr[0] <= cl_last[ADDR_W-1:0];
        ent_val[0]  <= cl_first;
        ent_addr[1] <= cl_first[ADDR_W-1:0];
        ent_val[1]  <= cl_last;
      end
      default: begin
      end
    endcase
  end

  // Output register
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (out_load) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      m_tdata <= {3'b000, ent_val[emit_idx], ent_addr[emit_idx]};
      m_tlast <= emit_last;
    end
  end

`ifndef SYNTHESIS
  a_start_sweeps: assert property (@(posedge clk) disable iff (rst)
    (state == ST_IDLE && !q_empty && head.kind == CMD_START)
      |=> (state == ST_CLEAR && clr_cnt == '0))
    else $error("start command did not begin a table sweep");

  a_emit_count: assert property (@(posedge clk) disable iff (rst)
    (state == ST_EMIT) |-> (ent_cnt != '0 && ent_cnt <= ECW'(MAX_WRITES)))
    else $error("emitting with an invalid result count");

  a_no_table_write: assert property (@(posedge clk) disable iff (rst)
    (state == ST_IDLE || state == ST_EMIT) |-> (!first_we && !last_we))
    else $error("table written outside sweep or update steps");

  a_no_pop_busy: assert property (@(posedge clk) disable iff (rst)
    (state != ST_IDLE) |-> !q_pop)
    else $error("command popped while back end busy");
`endif

endmodule

@@ rtl/core/sse_vertex_list_linker.sv @@
// Top level of the vertex list linker: front end, command queue, back end.
// Depends on svl_pkg, svl_front, svl_queue, svl_back (and svl_ram below it).
//
//  Channel  | Dir | Signals                          | Contents
//  ---------+-----+----------------------------------+-------------------------------
//  s_*      | in  | s_tvalid s_tready s_tdata s_tuser | request: type, slot, sites
//  m_*      | out | m_tvalid m_tready m_tdata m_tlast | vertex list write, last flag
//
// An operator slot yields 0, 2 or 4 vertex list writes, an empty slot 4 and a
// close request 0 or 2. For an operator slot the back end reads the per-site
// last-vertex RAM twice and writes each table twice, on one port per RAM.
// Reset and start requests sweep both site tables, one entry per cycle; no
// input transfer is taken during the sweep.
// A stalled output holds the result register; the queue takes input until full.
module sse_vertex_list_linker #(
  parameter int MAX_SITES = svl_pkg::MAX_SITES_DEF
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         s_tvalid,
  output logic                         s_tready,
  // slot_index[11:0], slot_occupied[12], site_a[22:13], site_b[32:23]
  input  logic [svl_pkg::S_DATA_W-1:0] s_tdata,
  // req_type[1:0]
  input  logic [svl_pkg::S_USER_W-1:0] s_tuser,
  output logic                         m_tvalid,
  input  logic                         m_tready,
  // write_addr[13:0], write_value[28:14]
  output logic [svl_pkg::M_DATA_W-1:0] m_tdata,
  output logic                         m_tlast
);
  import svl_pkg::*;

  logic q_push;
  logic q_full;
  logic q_pop;
  logic q_empty;
  logic clearing;
  cmd_t q_entry;
  cmd_t q_head;

  svl_front #(.MAX_SITES(MAX_SITES)) u_front (
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .q_full   (q_full),
    .clearing (clearing),
    .q_push   (q_push),
    .q_entry  (q_entry)
  );

  svl_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (q_push),
    .push_entry (q_entry),
    .full       (q_full),
    .pop        (q_pop),
    .head       (q_head),
    .empty      (q_empty)
  );

  svl_back #(.MAX_SITES(MAX_SITES)) u_back (
    .clk      (clk),
    .rst      (rst),
    .head     (q_head),
    .q_empty  (q_empty),
    .q_pop    (q_pop),
    .clearing (clearing),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast)
  );

endmodule
